/* hdl/csvt_pkg.sv */
package csvt_pkg;

   localparam logic FUNC_DATA  = 1'b0;
   localparam logic FUNC_FLUSH = 1'b1;

   localparam logic [1:0] KIND_BYTE   = 2'd0;
   localparam logic [1:0] KIND_FIELD  = 2'd1;
   localparam logic [1:0] KIND_RECORD = 2'd2;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   localparam int FIFO_DEPTH = 4;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
   } res_type;

   typedef struct packed {
      logic    two;
      res_type r0;
      res_type r1;
   } pkt_type;

endpackage

/* hdl/csvt_fifo.sv */
module csvt_fifo
   import csvt_pkg::*;
#(
   parameter int DEPTH = FIFO_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  pkt_type push_pkt,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output pkt_type head_pkt
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pkt_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_pkt = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_pkt;
      end
   end

endmodule

/* hdl/csvt_front.sv */
module csvt_front
   import csvt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_func,
   input  logic [7:0] req_data_byte,
   input  logic       full,
   output logic       req_stall,
   output logic       push,
   output pkt_type    push_pkt
);

   logic cr_held_ff, cr_held_in;
   logic quoting_ff, quoting_in;
   logic quote_held_ff, quote_held_in;
   logic field_open_ff, field_open_in;
   logic rec_has_field_ff, rec_has_field_in;
   logic line_has_bytes_ff, line_has_bytes_in;

   logic       accept;
   logic [1:0] n;
   res_type    res [2];
   logic       done;
   logic [7:0] c;

   assign req_stall = full;
   assign accept    = req_valid && !full;
   assign c         = req_data_byte;

   always_comb begin
      cr_held_in        = cr_held_ff;
      quoting_in        = quoting_ff;
      quote_held_in     = quote_held_ff;
      field_open_in     = field_open_ff;
      rec_has_field_in  = rec_has_field_ff;
      line_has_bytes_in = line_has_bytes_ff;
      n                 = 2'd0;
      done              = 1'b0;
      res[0]            = '{kind: KIND_BYTE, data: 8'h00};
      res[1]            = '{kind: KIND_BYTE, data: 8'h00};

      if (req_func == FUNC_FLUSH) begin
         if (quote_held_ff) begin
            quoting_in = 1'b0;
         end
         if (line_has_bytes_ff) begin
            if (quoting_in) begin
               res[n[0]] = '{kind: KIND_BYTE, data: CH_LF};
               n = n + 2'd1;
            end
            res[n[0]] = '{kind: KIND_RECORD, data: 8'h00};
            n = n + 2'd1;
         end else if (quoting_in) begin
            res[n[0]] = '{kind: KIND_RECORD, data: 8'h00};
            n = n + 2'd1;
         end
         cr_held_in        = 1'b0;
         quoting_in        = 1'b0;
         quote_held_in     = 1'b0;
         field_open_in     = 1'b0;
         rec_has_field_in  = 1'b0;
         line_has_bytes_in = 1'b0;
      end else begin
         if (quote_held_ff) begin
            quote_held_in = 1'b0;
            if (c == CH_QUOTE) begin
               res[n[0]] = '{kind: KIND_BYTE, data: CH_QUOTE};
               n = n + 2'd1;
               line_has_bytes_in = 1'b1;
               done = 1'b1;
            end else begin
               quoting_in = 1'b0;
            end
         end
         if (!done) begin
            if (cr_held_in) begin
               cr_held_in = 1'b0;
               if (c != CH_LF) begin
                  res[n[0]] = '{kind: KIND_BYTE, data: CH_CR};
                  n = n + 2'd1;
                  field_open_in = 1'b1;
               end
            end
            if (c == CH_LF) begin
               if (quoting_in) begin
                  res[n[0]] = '{kind: KIND_BYTE, data: CH_LF};
                  n = n + 2'd1;
                  field_open_in = 1'b1;
               end else begin
                  res[n[0]] = '{kind: KIND_RECORD, data: 8'h00};
                  n = n + 2'd1;
                  field_open_in    = 1'b0;
                  rec_has_field_in = 1'b0;
               end
               line_has_bytes_in = 1'b0;
            end else begin
               if (c == CH_CR) begin
                  cr_held_in = 1'b1;
               end else if (c == CH_QUOTE) begin
                  if (quoting_in) begin
                     quote_held_in = 1'b1;
                  end else begin
                     quoting_in    = 1'b1;
                     field_open_in = 1'b1;
                  end
               end else if (c == CH_COMMA && !quoting_in) begin
                  res[n[0]] = '{kind: KIND_FIELD, data: 8'h00};
                  n = n + 2'd1;
                  field_open_in    = 1'b0;
                  rec_has_field_in = 1'b1;
               end else begin
                  res[n[0]] = '{kind: KIND_BYTE, data: c};
                  n = n + 2'd1;
                  field_open_in = 1'b1;
               end
               line_has_bytes_in = 1'b1;
            end
         end
      end
   end

   assign push         = accept && (n != 2'd0);
   assign push_pkt.two = (n == 2'd2);
   assign push_pkt.r0  = res[0];
   assign push_pkt.r1  = res[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         cr_held_ff        <= 1'b0;
         quoting_ff        <= 1'b0;
         quote_held_ff     <= 1'b0;
         field_open_ff     <= 1'b0;
         rec_has_field_ff  <= 1'b0;
         line_has_bytes_ff <= 1'b0;
      end else if (accept) begin
         cr_held_ff        <= cr_held_in;
         quoting_ff        <= quoting_in;
         quote_held_ff     <= quote_held_in;
         field_open_ff     <= field_open_in;
         rec_has_field_ff  <= rec_has_field_in;
         line_has_bytes_ff <= line_has_bytes_in;
      end
   end

endmodule

/* hdl/csvt_back.sv */
module csvt_back
   import csvt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       empty,
   input  pkt_type    head_pkt,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);

   logic       sel_ff, sel_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_kind_ff;
   logic [7:0] rsp_out_byte_ff;
   logic       rsp_last_ff;

   logic    load;
   logic    take;
   logic    pick_last;
   res_type pick;

   assign load      = !rsp_valid_ff || !rsp_stall;
   assign take      = load && !empty;
   assign pick      = sel_ff ? head_pkt.r1 : head_pkt.r0;
   assign pick_last = sel_ff || !head_pkt.two;
   assign pop       = take && pick_last;

   always_comb begin
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         sel_in       = !pick_last;
         rsp_valid_in = 1'b1;
      end else if (load) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_kind_ff     <= pick.kind;
         rsp_out_byte_ff <= pick.data;
         rsp_last_ff     <= pick_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_out_byte = rsp_out_byte_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

/* hdl/csv_field_tokenizer_top.sv */
// Streaming CSV tokenizer: one byte (or an end-of-input flush) is taken per
// transfer and turned into zero, one or two results (field byte, field end,
// record end), with last set on the final result of each input. The front
// end accepts one input per cycle while the result queue (DEPTH entries,
// one entry per input that yields results) has room; the back end drives one
// result per cycle from its output register while rsp_stall is low, so the
// two results of one input leave one after the other. A result passes through
// the result queue and then the output register on its way out. The sustained
// rate is one input per cycle when each input yields at most one result and
// rsp_stall is low, and is set by the single output register otherwise.
module csv_field_tokenizer_top
   import csvt_pkg::*;
#(
   parameter int DEPTH = FIFO_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_func,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last
);

   logic    full;
   logic    empty;
   logic    push;
   logic    pop;
   pkt_type push_pkt;
   pkt_type head_pkt;

   csvt_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_func      (req_func),
      .req_data_byte (req_data_byte),
      .full          (full),
      .req_stall     (req_stall),
      .push          (push),
      .push_pkt      (push_pkt)
   );

   csvt_fifo #(
      .DEPTH (DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_pkt (push_pkt),
      .full     (full),
      .pop      (pop),
      .empty    (empty),
      .head_pkt (head_pkt)
   );

   csvt_back u_back (
      .clock        (clock),
      .reset        (reset),
      .empty        (empty),
      .head_pkt     (head_pkt),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_kind     (rsp_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

/* hdl/csvt_checker.sv */
module csvt_checker
   import csvt_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last
);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("stalled result transfer changed");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_BYTE |-> rsp_last && rsp_out_byte == 8'h00)
      else $error("field or record end not last or carries a byte");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind == KIND_BYTE || rsp_kind == KIND_FIELD
         || rsp_kind == KIND_RECORD)
      else $error("illegal result kind");

endmodule

bind csv_field_tokenizer_top csvt_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_kind      (rsp_kind),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_last      (rsp_last)
);
